### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the RTL; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/core/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared constants for the 4x4 matrix-vector transform core.
// ----------------------------------------------------------------------------
package mvt_pkg;

    // Port width of every data field
    localparam int PORT_W = 32;

    // Matrix dimension
    localparam int N_DIM = 4;
    localparam int IDX_W = 2;

    // Request types
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_XFORM = 1'b1;

    typedef logic [PORT_W-1:0] port_word_t;

endpackage

### rtl/core/matrix_vector_transform_4x4_core.sv
// Matrix-vector transform core: holds a 4x4 signed fixed-point matrix
// (FRAC_BITS fraction bits, DATA_WIDTH significant bits, all entries zero
// after reset) and multiplies it by incoming four-component vectors. A load
// request writes one entry and returns nothing; a transform request returns
// the four row dot products, each shifted arithmetically right by FRAC_BITS
// (rounding toward minus infinity), saturated to DATA_WIDTH bits and
// sign-extended to 32, plus a flag set when any component was clamped.
// Throughput is one request per cycle while results are taken; a transform
// result passes through the input register, then the product register, then
// the result register. Loads take effect in request order, so a
// transform sees every load accepted ahead of it. Each pipeline stage moves
// on independently, so requests keep being accepted while a result waits at
// the output, until the input and product stages are also occupied.
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_core
// Three-stage pipelined 4x4 matrix times vector with saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_vector_transform_4x4_core #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_req_type,
    input  logic [mvt_pkg::IDX_W-1:0]  s_row,
    input  logic [mvt_pkg::IDX_W-1:0]  s_col,
    input  mvt_pkg::port_word_t        s_load_value,
    input  mvt_pkg::port_word_t        s_vec_x,
    input  mvt_pkg::port_word_t        s_vec_y,
    input  mvt_pkg::port_word_t        s_vec_z,
    input  mvt_pkg::port_word_t        s_vec_w,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output mvt_pkg::port_word_t        m_out_x,
    output mvt_pkg::port_word_t        m_out_y,
    output mvt_pkg::port_word_t        m_out_z,
    output mvt_pkg::port_word_t        m_out_w,
    output logic                       m_saturated
);

    import mvt_pkg::*;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int SUM_W  = PROD_W + 2;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    localparam data_t SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Stage enables
    logic en1;
    logic en2;
    logic en3;

    // Matrix storage
    data_t matrix_reg [N_DIM][N_DIM];

    // Stage 1: registered request
    logic             v1_reg;
    logic             xform1_reg;
    logic [IDX_W-1:0] row1_reg;
    logic [IDX_W-1:0] col1_reg;
    data_t            load1_reg;
    data_t            vec1_reg [N_DIM];
    data_t            vec1_next [N_DIM];

    // Stage 2: registered products
    logic  v2_reg;
    prod_t prod_reg  [N_DIM][N_DIM];
    prod_t prod_next [N_DIM][N_DIM];

    // Stage 3: result register
    logic       m_valid_reg;
    port_word_t out_reg  [N_DIM];
    port_word_t out_next [N_DIM];
    logic       sat_reg;
    logic       sat_next;

    sum_t sum_w   [N_DIM];
    sum_t shift_w [N_DIM];

    // Advance each stage when its successor is empty or moving
    assign en3     = !m_valid_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    // Keep only the significant low bits of the vector fields
    always_comb begin
        vec1_next[0] = s_vec_x[DATA_WIDTH-1:0];
        vec1_next[1] = s_vec_y[DATA_WIDTH-1:0];
        vec1_next[2] = s_vec_z[DATA_WIDTH-1:0];
        vec1_next[3] = s_vec_w[DATA_WIDTH-1:0];
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_valid;
        end
        if (en1 && s_valid) begin
            xform1_reg <= (s_req_type == REQ_XFORM);
            row1_reg   <= s_row;
            col1_reg   <= s_col;
            load1_reg  <= s_load_value[DATA_WIDTH-1:0];
            vec1_reg   <= vec1_next;
        end
    end

    // Write a matrix entry as the load leaves stage 1, in request order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < N_DIM; r++) begin
                for (int c = 0; c < N_DIM; c++) begin
                    matrix_reg[r][c] <= '0;
                end
            end
        end else if (v1_reg && !xform1_reg && en2) begin
            matrix_reg[row1_reg][col1_reg] <= load1_reg;
        end
    end

    // Form all sixteen full-width products
    always_comb begin
        for (int r = 0; r < N_DIM; r++) begin
            for (int c = 0; c < N_DIM; c++) begin
                prod_next[r][c] = prod_t'(matrix_reg[r][c]) * prod_t'(vec1_reg[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg && xform1_reg;
        end
        if (en2 && v1_reg && xform1_reg) begin
            prod_reg <= prod_next;
        end
    end

    // Sum each row, drop the fraction bits and saturate
    always_comb begin
        sat_next = 1'b0;
        for (int r = 0; r < N_DIM; r++) begin
            sum_w[r] = sum_t'(prod_reg[r][0]) + sum_t'(prod_reg[r][1])
                     + sum_t'(prod_reg[r][2]) + sum_t'(prod_reg[r][3]);
            shift_w[r] = sum_w[r] >>> FRAC_BITS;
            if ((&shift_w[r][SUM_W-1:DATA_WIDTH-1]) ||
                !(|shift_w[r][SUM_W-1:DATA_WIDTH-1])) begin
                out_next[r] = PORT_W'(data_t'(shift_w[r][DATA_WIDTH-1:0]));
            end else begin
                sat_next    = 1'b1;
                out_next[r] = shift_w[r][SUM_W-1] ? PORT_W'(SAT_MIN) : PORT_W'(SAT_MAX);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en3) begin
            m_valid_reg <= v2_reg;
        end
        if (en3 && v2_reg) begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    // Drive the result channel
    assign m_valid     = m_valid_reg;
    assign m_out_x     = out_reg[0];
    assign m_out_y     = out_reg[1];
    assign m_out_z     = out_reg[2];
    assign m_out_w     = out_reg[3];
    assign m_saturated = sat_reg;

    // A set flag means at least one component sits at a limit
    `ASSERT_IMPL(a_sat_at_limit, aclk, aresetn, m_valid_reg && sat_reg, (out_reg[0] == PORT_W'(SAT_MAX)) || (out_reg[0] == PORT_W'(SAT_MIN)) || (out_reg[1] == PORT_W'(SAT_MAX)) || (out_reg[1] == PORT_W'(SAT_MIN)) || (out_reg[2] == PORT_W'(SAT_MAX)) || (out_reg[2] == PORT_W'(SAT_MIN)) || (out_reg[3] == PORT_W'(SAT_MAX)) || (out_reg[3] == PORT_W'(SAT_MIN)), "saturated flag without a clamped component")
    // A product set moving on always lands in the result register
    `ASSERT_NEXT(a_stage2_to_out, aclk, aresetn, v2_reg && en3, m_valid_reg, "transform lost between product and result stage")
    // A departing load updates its entry
    `ASSERT_NEXT(a_load_write, aclk, aresetn, v1_reg && !xform1_reg && en2, matrix_reg[$past(row1_reg)][$past(col1_reg)] == $past(load1_reg), "matrix entry not written by load")
    // Backpressure reaches the input only when every pipeline stage is occupied
    `ASSERT_IMPL(a_ready_full, aclk, aresetn, !s_ready, v1_reg && v2_reg && m_valid_reg, "input stalled with room in the pipeline")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and transform requests into the 4x4 matrix-vector core, keeps
// a shadow copy of the matrix to predict each transform result, and compares
// every result field by field in arrival order. Both channels idle and stall
// in random bursts, and one long output hold-off backs the pipeline up.
// ----------------------------------------------------------------------------
module testbench;
    import mvt_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int DW_SHIFT    = PORT_W - DATA_WIDTH;
    localparam int RANDOM_REQS = 2000;
    localparam int QUIET_FROM  = 1800;
    localparam int HOLD_AT     = 500;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;

    localparam port_word_t MAX_WORD    = 32'h7FFF_FFFF;
    localparam port_word_t MIN_WORD    = 32'h8000_0000;
    localparam port_word_t ONE_Q       = 32'h0001_0000;
    localparam port_word_t MINUS_ONE_Q = 32'hFFFF_0000;

    typedef logic [N_DIM-1:0][PORT_W-1:0] vec4_t;

    typedef struct packed {
        vec4_t comp;
        logic  sat;
    } xform_result_t;

    // Shadow matrix plus the queue of transform results still owed
    class xform_scoreboard;
        logic signed [PORT_W-1:0] coeff [N_DIM*N_DIM];
        xform_result_t            owed [$];
        int                       failures;

        function new();
            foreach (coeff[i]) coeff[i] = '0;
            failures = 0;
        endfunction

        // Keep only the low DATA_WIDTH bits, read as signed
        function logic signed [PORT_W-1:0] sext_data(port_word_t w);
            return $signed(w << DW_SHIFT) >>> DW_SHIFT;
        endfunction

        function xform_result_t apply_matrix(vec4_t vec);
            xform_result_t    res;
            logic signed [67:0] acc, term_a, term_b, scaled, hi_lim, lo_lim;
            hi_lim = (68'sd1 <<< (DATA_WIDTH - 1)) - 68'sd1;
            lo_lim = -(68'sd1 <<< (DATA_WIDTH - 1));
            res.sat = 1'b0;
            for (int r = 0; r < N_DIM; r++) begin
                acc = '0;
                for (int c = 0; c < N_DIM; c++) begin
                    term_a = coeff[r*N_DIM + c];
                    term_b = sext_data(vec[c]);
                    acc += term_a * term_b;
                end
                // floor shift, then clamp to the data width
                scaled = acc >>> FRAC_BITS;
                if (scaled > hi_lim) begin
                    scaled  = hi_lim;
                    res.sat = 1'b1;
                end else if (scaled < lo_lim) begin
                    scaled  = lo_lim;
                    res.sat = 1'b1;
                end
                res.comp[r] = scaled[PORT_W-1:0];
            end
            return res;
        endfunction

        function void note_request(logic req_type, logic [IDX_W-1:0] row,
                                   logic [IDX_W-1:0] col, port_word_t load_value,
                                   vec4_t vec);
            if (req_type == REQ_LOAD) begin
                coeff[{row, col}] = sext_data(load_value);
            end else begin
                owed.push_back(apply_matrix(vec));
            end
        endfunction

        function void flag_error(string msg);
            failures++;
            if (failures <= 10) begin
                $display("[%0t] MISMATCH %s", $time, msg);
            end
        endfunction

        function void check_result(vec4_t comp, logic sat);
            string         names [N_DIM] = '{"out_x", "out_y", "out_z", "out_w"};
            xform_result_t want;
            if (owed.size() == 0) begin
                flag_error($sformatf("result with none owed: %h %h %h %h sat %b",
                           comp[0], comp[1], comp[2], comp[3], sat));
                return;
            end
            want = owed.pop_front();
            for (int i = 0; i < N_DIM; i++) begin
                if (comp[i] !== want.comp[i]) begin
                    flag_error($sformatf("%s expected %h actual %h",
                               names[i], want.comp[i], comp[i]));
                end
            end
            if (sat !== want.sat) begin
                flag_error($sformatf("saturated expected %b actual %b", want.sat, sat));
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_req_type;
    logic [IDX_W-1:0] s_row;
    logic [IDX_W-1:0] s_col;
    port_word_t s_load_value;
    port_word_t s_vec_x;
    port_word_t s_vec_y;
    port_word_t s_vec_z;
    port_word_t s_vec_w;
    logic       m_valid;
    logic       m_ready;
    port_word_t m_out_x;
    port_word_t m_out_y;
    port_word_t m_out_z;
    port_word_t m_out_w;
    logic       m_saturated;

    bit quiet;
    bit long_hold_due;
    int stall_cycles;

    xform_scoreboard sb = new();

    matrix_vector_transform_4x4_core #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_load_value (s_load_value),
        .s_vec_x      (s_vec_x),
        .s_vec_y      (s_vec_y),
        .s_vec_z      (s_vec_z),
        .s_vec_w      (s_vec_w),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_out_z      (m_out_z),
        .m_out_w      (m_out_w),
        .m_saturated  (m_saturated)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Record every accepted request: loads update the shadow matrix, transforms queue a prediction
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_req_type, s_row, s_col, s_load_value,
                            {s_vec_w, s_vec_z, s_vec_y, s_vec_x});
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_out_w, m_out_z, m_out_y, m_out_x}, m_saturated);
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Result side: random ready and stall bursts, one long hold-off
    initial begin
        int burst;
        bit long_hold_done;
        long_hold_done = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            burst = $urandom_range(1, 16);
            if (long_hold_due && !long_hold_done) begin
                long_hold_done = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else if (quiet || $urandom_range(2) != 0) begin
                repeat (quiet ? 1 : $urandom_range(1, 64)) begin
                    @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end else begin
                repeat (burst) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(input logic req_type, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col, input port_word_t load_value,
                                input vec4_t vec);
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_req_type   <= req_type;
        s_row        <= row;
        s_col        <= col;
        s_load_value <= load_value;
        s_vec_x      <= vec[0];
        s_vec_y      <= vec[1];
        s_vec_z      <= vec[2];
        s_vec_w      <= vec[3];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Mix of corner values, small Q16.16 values and full-range words
    function automatic port_word_t random_word();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(6))
                    0: return MAX_WORD;
                    1: return MIN_WORD;
                    2: return '0;
                    3: return '1;
                    4: return 32'h0000_0001;
                    5: return ONE_Q;
                    default: return MINUS_ONE_Q;
                endcase
            end
            1, 2, 3: return port_word_t'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec4_t random_vec();
        vec4_t v;
        for (int i = 0; i < N_DIM; i++) v[i] = random_word();
        return v;
    endfunction

    // Loads carry random vectors, which the block must ignore
    task automatic load_entry(input int row, input int col, input port_word_t value);
        send_request(REQ_LOAD, IDX_W'(row), IDX_W'(col), value, random_vec());
    endtask

    // Transforms carry random entry fields, which the block must ignore
    task automatic transform_vector(input vec4_t vec);
        send_request(REQ_XFORM, IDX_W'($urandom), IDX_W'($urandom), $urandom, vec);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req_type    = REQ_LOAD;
        s_row         = '0;
        s_col         = '0;
        s_load_value  = '0;
        s_vec_x       = '0;
        s_vec_y       = '0;
        s_vec_z       = '0;
        s_vec_w       = '0;
        quiet         = 1'b0;
        long_hold_due = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero matrix after reset yields zero whatever the vector
        transform_vector({MAX_WORD, MIN_WORD, MAX_WORD, MIN_WORD});

        // Diagonal of max, min, one and minus one
        load_entry(0, 0, MAX_WORD);
        load_entry(1, 1, MIN_WORD);
        load_entry(2, 2, ONE_Q);
        load_entry(3, 3, MINUS_ONE_Q);

        // Clamp both ways, hit the limits exactly, floor negative products
        transform_vector({4{MAX_WORD}});
        transform_vector({4{MIN_WORD}});
        transform_vector({4{32'h0000_0001}});
        transform_vector({4{32'hFFFF_FFFF}});

        // Fill rows 0 and 1 with extremes so the sum overflows 64 bits
        load_entry(0, 1, MAX_WORD);
        load_entry(0, 2, MAX_WORD);
        load_entry(0, 3, MAX_WORD);
        load_entry(1, 0, MIN_WORD);
        load_entry(1, 2, MIN_WORD);
        load_entry(1, 3, MIN_WORD);
        transform_vector({4{MIN_WORD}});
        transform_vector({4{MAX_WORD}});
        transform_vector({MIN_WORD, MAX_WORD, ONE_Q, MINUS_ONE_Q});

        // Random loads and transforms with bursty idling
        for (int i = 0; i < RANDOM_REQS; i++) begin
            bit gaps_on;
            if (i % 100 == 0) gaps_on = $urandom_range(1);
            if (i == HOLD_AT) long_hold_due = 1'b1;
            if (i == QUIET_FROM) quiet = 1'b1;
            if ($urandom_range(9) < 4) begin
                load_entry($urandom_range(3), $urandom_range(3), random_word());
            end else begin
                transform_vector(random_vec());
            end
            if (!quiet && gaps_on && $urandom_range(3) == 0) begin
                idle_sender($urandom_range(1, 16));
            end
        end
        idle_sender(1);

        // Drain owed results, then watch for strays
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.failures == 0 && sb.owed.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
